### design/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int CLE_LINE_CAPACITY = 64;

  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_DEL = 8'h7f;
  localparam logic [7:0] BYTE_SP  = 8'h20;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  // Kind of work held for the result side
  typedef enum logic [1:0] {
    JOB_ECHO  = 2'd0,
    JOB_EOL   = 2'd1,
    JOB_ERASE = 2'd2,
    JOB_READ  = 2'd3
  } job_kind_t;

  // Payload of one result beat
  typedef struct packed {
    logic       is_echo;
    logic [7:0] out_byte;
    logic       line_done;
    logic [5:0] line_length;
    logic       last;
  } beat_t;

endpackage

### design/cle_if.sv
// ----------------------------------------------------------------------------
// cle_in_if / cle_out_if
// Valid/ready channels for edit commands and result beats.
// ----------------------------------------------------------------------------
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  logic [5:0] read_index;

  modport source (output valid, output cmd, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input cmd, input rx_byte, input read_index,
                  output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic       is_echo;
  logic [7:0] out_byte;
  logic       line_done;
  logic [5:0] line_length;
  logic       last;

  modport source (output valid, output is_echo, output out_byte, output line_done,
                  output line_length, output last, input ready);
  modport sink   (input valid, input is_echo, input out_byte, input line_done,
                  input line_length, input last, output ready);
endinterface

### design/console_line_editor.sv
// ----------------------------------------------------------------------------
// console_line_editor
// Line editor for a serial console: stores, erases and terminates lines and
// produces the echo beats; also answers reads of the line store.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the job registers; each result beat is
//   built from the held job and loaded into the output register for out_ch.
// Throughput: one item per cycle for single-beat items while out_ch is ready;
//   a line end sends CR then LF and an erase BS, SP, BS, through the one output
//   register, one beat per cycle when out_ch takes it; zero-beat items hold no job.
// Reset (synchronous, rst_n low): fill count and valid flags cleared; the
//   line store keeps no reset and is undefined until written.
// ----------------------------------------------------------------------------
module console_line_editor
  import cle_pkg::*;
#(
  parameter int LINE_CAPACITY = CLE_LINE_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  cle_in_if.sink    in_ch,
  cle_out_if.source out_ch
);

  localparam int FILL_W = $clog2(LINE_CAPACITY);
  // wide enough for the capacity itself and for a 6-bit index or length
  localparam int CMP_W  = (FILL_W + 1 > 6) ? FILL_W + 1 : 6;

  // --- line state --------------------------------------------------------
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // --- job held for the result side (one item at a time) -----------------
  logic              job_valid_r, job_valid_nxt;
  job_kind_t         job_kind_r;
  logic [1:0]        job_beat_r,  job_beat_nxt;
  logic [7:0]        job_ch_r;
  logic [5:0]        job_len_r;
  logic              job_oob_r;

  // --- output register -----------------------------------------------------
  logic              out_valid_r, out_valid_nxt;
  beat_t             out_beat_r;

  // --- decode of the incoming beat ----------------------------------------
  logic              in_fire;
  logic              is_eol, is_erase, erase_ok, plain_ok, has_job;
  job_kind_t         kind_in;
  logic [CMP_W-1:0]  idx_ext, fill_ext;
  logic              oob_in;

  // --- line store ----------------------------------------------------------
  logic              ram_we, ram_re;
  logic [7:0]        ram_wdata, ram_rdata;

  // --- beat sequencing -----------------------------------------------------
  beat_t             beat;
  logic              out_load, job_done;

  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    is_eol   = !in_ch.cmd && (in_ch.rx_byte == BYTE_CR || in_ch.rx_byte == BYTE_LF);
    is_erase = !in_ch.cmd && (in_ch.rx_byte == BYTE_DEL || in_ch.rx_byte == BYTE_BS);
    erase_ok = is_erase && (fill_r != '0);
    // room while fewer than capacity minus one characters are held
    plain_ok = !in_ch.cmd && !is_eol && !is_erase
               && (fill_r != FILL_W'(LINE_CAPACITY - 1));
    has_job  = in_ch.cmd || is_eol || erase_ok || plain_ok;

    if (in_ch.cmd) begin
      kind_in = JOB_READ;
    end else if (is_eol) begin
      kind_in = JOB_EOL;
    end else if (is_erase) begin
      kind_in = JOB_ERASE;
    end else begin
      kind_in = JOB_ECHO;
    end

    idx_ext  = CMP_W'(in_ch.read_index);
    fill_ext = CMP_W'(fill_r);
    oob_in   = idx_ext >= CMP_W'(LINE_CAPACITY);
  end

  // Fill count follows the edit at the accept edge
  always_comb begin
    fill_nxt = fill_r;
    if (in_fire) begin
      if (is_eol) begin
        fill_nxt = '0;
      end else if (erase_ok) begin
        fill_nxt = fill_r - FILL_W'(1);
      end else if (plain_ok) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  // Store writes a terminator on line end, the byte on a plain insert
  assign ram_we    = in_fire && (is_eol || plain_ok);
  assign ram_wdata = is_eol ? BYTE_NUL : in_ch.rx_byte;
  assign ram_re    = in_fire && in_ch.cmd;

  cle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_ext[FILL_W-1:0]),
    .rdata (ram_rdata)
  );

  // Beat for the current job position. Read data is stable while the read
  // job is held: no other read can be accepted until it leaves.
  always_comb begin
    beat = '0;
    beat.is_echo = 1'b1;
    case (job_kind_r)
      JOB_ECHO: begin
        beat.out_byte = job_ch_r;
        beat.last     = 1'b1;
      end
      JOB_EOL: begin
        if (job_beat_r == 2'd0) begin
          beat.out_byte = BYTE_CR;
        end else begin
          beat.out_byte    = BYTE_LF;
          beat.line_done   = 1'b1;
          beat.line_length = job_len_r;
          beat.last        = 1'b1;
        end
      end
      JOB_ERASE: begin
        beat.out_byte = (job_beat_r == 2'd1) ? BYTE_SP : BYTE_BS;
        beat.last     = (job_beat_r == 2'd2);
      end
      JOB_READ: begin
        beat.is_echo  = 1'b0;
        beat.out_byte = job_oob_r ? BYTE_NUL : ram_rdata;
        beat.last     = 1'b1;
      end
      default: begin
        beat = '0;
      end
    endcase
  end

  assign out_load = job_valid_r && (!out_valid_r || out_ch.ready);
  assign job_done = out_load && beat.last;

  // A new item may enter as the held job sends its final beat
  assign in_ch.ready = !job_valid_r || job_done;

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_beat_nxt  = job_beat_r;
    if (in_fire && has_job) begin
      job_valid_nxt = 1'b1;
      job_beat_nxt  = 2'd0;
    end else if (job_done) begin
      job_valid_nxt = 1'b0;
    end else if (out_load) begin
      job_beat_nxt  = job_beat_r + 2'd1;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      job_valid_r <= 1'b0;
      job_beat_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      job_valid_r <= job_valid_nxt;
      job_beat_r  <= job_beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_fire && has_job) begin
      job_kind_r <= kind_in;
      job_ch_r   <= in_ch.rx_byte;
      job_len_r  <= fill_ext[5:0];
      job_oob_r  <= oob_in;
    end
    if (out_load) begin
      out_beat_r <= beat;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_echo     = out_beat_r.is_echo;
  assign out_ch.out_byte    = out_beat_r.out_byte;
  assign out_ch.line_done   = out_beat_r.line_done;
  assign out_ch.line_length = out_beat_r.line_length;
  assign out_ch.last        = out_beat_r.last;

endmodule

### design/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks for the console line editor, bound to the top level.
// ----------------------------------------------------------------------------
module cle_checker
  import cle_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_echo,
  input logic [7:0] out_byte,
  input logic       out_line_done,
  input logic [5:0] out_line_length,
  input logic       out_last
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result beat changed while stalled");

  // a completed line ends on the LF echo
  a_done_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done |-> out_is_echo && out_last && out_byte == BYTE_LF)
    else $error("line_done not on final LF echo");

  // read answers are single beats
  a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_echo |-> out_last && !out_line_done)
    else $error("read answer not a single beat");

  // length only reported with line_done
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_done |-> out_line_length == 6'd0)
    else $error("line_length set outside line_done");

  // beats of one item follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a multi-beat result");

endmodule

bind console_line_editor cle_checker u_cle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_is_echo     (out_ch.is_echo),
  .out_byte        (out_ch.out_byte),
  .out_line_done   (out_ch.line_done),
  .out_line_length (out_ch.line_length),
  .out_last        (out_ch.last)
);

### test/cle_echo_scoreboard.sv
// ----------------------------------------------------------------------------
// cle_echo_scoreboard
// Watches both channels of the console line editor, keeps its own copy of the
// line store and fill count, predicts the result beats of every accepted item
// and compares them, field by field, with what leaves the block.
// ----------------------------------------------------------------------------
module cle_echo_scoreboard
  import cle_pkg::*;
#(
  parameter int LINE_CAPACITY = CLE_LINE_CAPACITY
) (
  input  logic clk,
  input  logic rst_n,
  cle_in_if    in_ch,
  cle_out_if   out_ch,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_CAP = 50;

  logic [7:0] line_mem [LINE_CAPACITY];
  int         fill;
  beat_t      echo_q[$];

  initial begin
    errors  = 0;
    pending = 0;
    fill    = 0;
  end

  function automatic job_kind_t classify(logic cmd, logic [7:0] rx);
    if (cmd) return JOB_READ;
    if (rx == BYTE_CR || rx == BYTE_LF) return JOB_EOL;
    if (rx == BYTE_BS || rx == BYTE_DEL) return JOB_ERASE;
    return JOB_ECHO;
  endfunction

  function automatic beat_t make_beat(logic echo, logic [7:0] b, logic done,
                                      logic [5:0] len, logic lst);
    beat_t r;
    r.is_echo     = echo;
    r.out_byte    = b;
    r.line_done   = done;
    r.line_length = len;
    r.last        = lst;
    return r;
  endfunction

  // Edit the shadow line and queue the beats the item should produce
  task automatic edit_line(logic cmd, logic [7:0] rx, logic [5:0] idx);
    logic [7:0] stored;
    int         len;
    case (classify(cmd, rx))
      JOB_READ: begin
        stored = (int'(idx) < LINE_CAPACITY) ? line_mem[idx] : BYTE_NUL;
        echo_q.push_back(make_beat(1'b0, stored, 1'b0, 6'd0, 1'b1));
      end
      JOB_EOL: begin
        len = fill;
        if (fill < LINE_CAPACITY) line_mem[fill] = BYTE_NUL;
        fill = 0;
        echo_q.push_back(make_beat(1'b1, BYTE_CR, 1'b0, 6'd0, 1'b0));
        echo_q.push_back(make_beat(1'b1, BYTE_LF, 1'b1, len[5:0], 1'b1));
      end
      JOB_ERASE: begin
        if (fill != 0) begin
          fill--;
          echo_q.push_back(make_beat(1'b1, BYTE_BS, 1'b0, 6'd0, 1'b0));
          echo_q.push_back(make_beat(1'b1, BYTE_SP, 1'b0, 6'd0, 1'b0));
          echo_q.push_back(make_beat(1'b1, BYTE_BS, 1'b0, 6'd0, 1'b1));
        end
      end
      default: begin
        if (fill < LINE_CAPACITY - 1) begin
          line_mem[fill] = rx;
          fill++;
          echo_q.push_back(make_beat(1'b1, rx, 1'b0, 6'd0, 1'b1));
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      if (errors < REPORT_CAP)
        $error("%s: expected %02h, got %02h", name, want, seen);
      errors++;
    end
  endtask

  task automatic check_beat();
    beat_t want;
    if (echo_q.size() == 0) begin
      if (errors < REPORT_CAP)
        $error("unexpected beat: out_byte %02h", out_ch.out_byte);
      errors++;
    end else begin
      want = echo_q.pop_front();
      check_field("is_echo",     8'(want.is_echo),     8'(out_ch.is_echo));
      check_field("out_byte",    want.out_byte,        out_ch.out_byte);
      check_field("line_done",   8'(want.line_done),   8'(out_ch.line_done));
      check_field("line_length", 8'(want.line_length), 8'(out_ch.line_length));
      check_field("last",        8'(want.last),        8'(out_ch.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      echo_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        edit_line(in_ch.cmd, in_ch.rx_byte, in_ch.read_index);
      if (out_ch.valid && out_ch.ready)
        check_beat();
    end
    pending = echo_q.size();
  end

endmodule

### test/console_line_editor_tb.sv
// ----------------------------------------------------------------------------
// console_line_editor_tb
// Drives the console line editor with received bytes and line store reads:
// a short directed opening, a full line typed against a stalled receiver,
// then random lines, erases, reads and noise. The scoreboard beside the block
// predicts and checks every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module console_line_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 2000;  // cycles without any beat before giving up
  localparam int ITEM_TARGET  = 320;   // items that cause at least one beat
  localparam int QUIET_FROM   = 280;   // no idling from here on
  localparam int TAIL_CYCLES  = 20;    // settle time after the last beat

  logic clk;
  logic rst_n;

  cle_in_if  in_ch ();
  cle_out_if out_ch ();

  int errors;
  int pending;

  // Stimulus-side shadow: which store entries hold data, so that a read never
  // lands on an entry that was never written, and how full the line is.
  bit written [CLE_LINE_CAPACITY];
  int line_fill;
  int produced;   // accepted items that cause beats; ignored ones do not count

  bit quiet;      // end of run: no gaps on either side
  bit hold_req;   // asks the receiver for one long hold-off

  console_line_editor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cle_echo_scoreboard echo_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run of cycles with no beat on either channel means a hang.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, stretches of steady acceptance, and one
  // long hold-off on request. Changes at falling edges.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Offer one beat on the input channel, maybe after a gap.
  // Entered and left at a falling edge; valid stays high between
  // back-to-back items.
  task automatic offer_item(logic cmd, logic [7:0] rx, logic [5:0] idx);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.cmd        = cmd;
    in_ch.rx_byte    = rx;
    in_ch.read_index = idx;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);

    // follow the line so later reads stay on written entries
    if (cmd) begin
      produced++;
    end else if (rx == BYTE_CR || rx == BYTE_LF) begin
      written[line_fill] = 1'b1;
      line_fill = 0;
      produced++;
    end else if (rx == BYTE_BS || rx == BYTE_DEL) begin
      if (line_fill > 0) begin
        line_fill--;
        produced++;
      end
    end else if (line_fill < CLE_LINE_CAPACITY - 1) begin
      written[line_fill] = 1'b1;
      line_fill++;
      produced++;
    end
  endtask

  // Any byte that the editor stores rather than acts on; high bit included.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == BYTE_CR || b == BYTE_LF ||
                                b == BYTE_BS || b == BYTE_DEL);
    return b;
  endfunction

  task automatic send_char();
    offer_item(1'b0, plain_byte(), 6'($urandom));
  endtask

  task automatic send_erase();
    offer_item(1'b0, $urandom_range(0, 1) ? BYTE_BS : BYTE_DEL, 6'($urandom));
  endtask

  task automatic send_eol();
    offer_item(1'b0, $urandom_range(0, 1) ? BYTE_CR : BYTE_LF, 6'($urandom));
  endtask

  // Read a random entry among those already written; the read beat is the
  // only one with is_echo low.
  task automatic send_read();
    int pool[$];
    foreach (written[i]) if (written[i]) pool.push_back(i);
    if (pool.size() == 0)
      send_char();
    else
      offer_item(1'b1, 8'($urandom), 6'(pool[$urandom_range(0, pool.size() - 1)]));
  endtask

  // A typed line: mostly characters, some corrections and reads, then CR or LF
  task automatic send_line(int len);
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 3)      send_erase();
      else if (pick < 5) send_read();
      else               send_char();
    end
    send_eol();
  endtask

  // Sender pause: nothing more is offered until every beat has come back
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int mode;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = 1'b0;
    in_ch.rx_byte    = 8'h00;
    in_ch.read_index = 6'd0;
    quiet            = 1'b0;
    hold_req         = 1'b0;
    line_fill        = 0;
    produced         = 0;
    foreach (written[i]) written[i] = 1'b0;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed opening ---
    // erase on an empty line: no beat at all
    offer_item(1'b0, BYTE_BS, 6'd0);
    offer_item(1'b0, BYTE_DEL, 6'd63);
    // line ends on an empty line, length zero; terminator lands at entry 0
    offer_item(1'b0, BYTE_CR, 6'd0);
    offer_item(1'b1, 8'hff, 6'd0);
    offer_item(1'b0, BYTE_LF, 6'd0);
    // extremes of the byte range, zero byte stored like any other
    offer_item(1'b0, 8'h00, 6'd0);
    offer_item(1'b0, 8'hff, 6'd0);
    offer_item(1'b0, 8'h41, 6'd0);
    offer_item(1'b0, 8'h80, 6'd0);
    offer_item(1'b0, 8'h7e, 6'd0);
    offer_item(1'b0, 8'h09, 6'd0);
    // erase on a non-empty line, both codes
    offer_item(1'b0, BYTE_DEL, 6'd0);
    offer_item(1'b0, BYTE_BS, 6'd0);
    offer_item(1'b0, 8'h55, 6'd0);
    // reads of live and of erased (stale) entries
    offer_item(1'b1, 8'h00, 6'd0);
    offer_item(1'b1, 8'h00, 6'd1);
    offer_item(1'b1, 8'h00, 6'd4);
    offer_item(1'b1, 8'h00, 6'd5);
    // line of five ends; zero terminator overwrites entry 5
    offer_item(1'b0, BYTE_LF, 6'd0);
    offer_item(1'b1, 8'h00, 6'd5);
    offer_item(1'b1, 8'h00, 6'd3);

    wait_drained();

    // --- full line against a stalled receiver ---
    // The receiver holds off while a line longer than the store is typed:
    // the block backs up and stalls its input; once the line is full the
    // surplus characters are dropped. The end of line reports length 63 and
    // puts its terminator in the top entry.
    hold_req = 1'b1;
    repeat (CLE_LINE_CAPACITY + 6) send_char();
    send_eol();
    wait_drained();
    offer_item(1'b1, 8'($urandom), 6'd63);
    offer_item(1'b1, 8'($urandom), 6'd62);

    // --- random part ---
    while (produced < ITEM_TARGET) begin
      if (produced >= QUIET_FROM) quiet = 1'b1;
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        // now and then a long line that runs into the capacity
        send_line(($urandom_range(0, 7) == 0) ? $urandom_range(40, 70)
                                              : $urandom_range(0, 12));
      end else if (mode <= 7) begin
        repeat ($urandom_range(1, 4)) send_read();
      end else begin
        // noise: any byte at all, line ends and erases among them
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) send_read();
          else offer_item(1'b0, 8'($urandom), 6'($urandom));
        end
      end
    end

    in_ch.valid = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
